// ===== sv/vector_normalize_macros.svh =====
// Assertion macros shared by the vector normalizer RTL.
// Depends on nothing; users supply clk and rst in their own scope.
`ifndef VECTOR_NORMALIZE_MACROS_SVH
`define VECTOR_NORMALIZE_MACROS_SVH

// Implication checked at every clock edge outside reset
`define VN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must never hold outside reset
`define VN_ASSERT_NEVER(lbl, bad, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(bad)) else $error(msg);

`endif

// ===== sv/vnorm_pkg.sv =====
// Shared widths, constants and stage structs for the vector normalizer.
// Used by the square root cell, the divide cell and the top level.
package vnorm_pkg;

  localparam int COMP_W     = 32;            // component width
  localparam int LIMIT_W    = 16;            // zero length limit width
  localparam int SQRT_STEPS = 32;            // one root bit per cell
  localparam int DIV_STEPS  = 32;            // one quotient bit per cell
  localparam int REM_W      = 34;            // square root partial remainder
  localparam int LANES      = 3;
  localparam logic [COMP_W-1:0] UNIT_ONE = 32'h4000_0000;

  // magnitudes and signs traveling alongside the length computation
  typedef struct packed {
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] my;
    logic [COMP_W-1:0] mz;
    logic              nx;
    logic              ny;
    logic              nz;
    logic              flat;
  } side_t;

  // one word in the square root chain
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [COMP_W-1:0]   root;
    logic [2*COMP_W-1:0] rad;
    side_t               side;
  } sqrt_t;

  typedef struct packed {
    logic zero;
    logic flat;
    logic nx;
    logic ny;
    logic nz;
  } flags_t;

  // one word in the divide chain, three lanes in parallel
  typedef struct packed {
    logic [LANES-1:0][COMP_W-1:0] rem;
    logic [LANES-1:0][COMP_W-1:0] low;
    logic [LANES-1:0][COMP_W-1:0] quo;
    logic [COMP_W-1:0]            len;
    flags_t                       fl;
  } div_t;

  typedef struct packed {
    logic [COMP_W-1:0] ux;
    logic [COMP_W-1:0] uy;
    logic [COMP_W-1:0] uz;
    logic              zero;
  } res_t;

endpackage

// ===== sv/vnorm_sqrt_cell.sv =====
// One digit-by-digit integer square root step: two radicand bits in, one root bit out.
// Depends on vnorm_pkg.
module vnorm_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_i,
  input  vnorm_pkg::sqrt_t d_i,
  output logic             vld_o,
  output vnorm_pkg::sqrt_t d_o
);
  import vnorm_pkg::*;

  logic [REM_W+1:0] wide;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  sqrt_t            d_next;

  // trial subtract of (4*root + 1) from the shifted remainder
  always_comb begin
    wide  = {d_i.rem, d_i.rad[2*COMP_W-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    diff  = wide - trial;
    ge    = (wide >= trial);
    d_next      = d_i;
    d_next.rem  = ge ? diff[REM_W-1:0] : wide[REM_W-1:0];
    d_next.root = {d_i.root[COMP_W-2:0], ge};
    d_next.rad  = {d_i.rad[2*COMP_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_next;
    end
  end

endmodule

// ===== sv/vnorm_div_cell.sv =====
// One restoring divide step for all three lanes: one quotient bit per lane.
// Depends on vnorm_pkg.
module vnorm_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_i,
  input  vnorm_pkg::div_t d_i,
  output logic            vld_o,
  output vnorm_pkg::div_t d_o
);
  import vnorm_pkg::*;

  logic [LANES-1:0][COMP_W:0] t;
  logic [LANES-1:0][COMP_W:0] diff;
  logic [LANES-1:0]           ge;
  div_t                       d_next;

  // shift in next numerator bit, subtract length when it fits
  always_comb begin
    d_next = d_i;
    for (int i = 0; i < LANES; i++) begin
      t[i]    = {d_i.rem[i], d_i.low[i][COMP_W-1]};
      diff[i] = t[i] - {1'b0, d_i.len};
      ge[i]   = (t[i] >= {1'b0, d_i.len});
      d_next.rem[i] = ge[i] ? diff[i][COMP_W-1:0] : t[i][COMP_W-1:0];
      d_next.low[i] = {d_i.low[i][COMP_W-2:0], 1'b0};
      d_next.quo[i] = {d_i.quo[i][COMP_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_o <= d_next;
    end
  end

endmodule

// ===== sv/vector_normalize.sv =====
// A word passes the capture, square and sum registers, both chains and the output buffer.
// Throughput: one vector per cycle unless stalled; a 32-cell square root chain and a 32-cell
// divide chain each retire one bit per cell per cycle, all cells advancing together.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst, synchronous) empties the pipeline and buffer and clears the limit to 0.
module vector_normalize (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [vnorm_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [vnorm_pkg::COMP_W-1:0] in_x,
  input  logic signed [vnorm_pkg::COMP_W-1:0] in_y,
  input  logic signed [vnorm_pkg::COMP_W-1:0] in_z,
  input  logic                           two_dims,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [vnorm_pkg::COMP_W-1:0] unit_x,
  output logic signed [vnorm_pkg::COMP_W-1:0] unit_y,
  output logic signed [vnorm_pkg::COMP_W-1:0] unit_z,
  output logic                           length_was_zero
);
  import vnorm_pkg::*;

  logic [LIMIT_W-1:0]  limit;
  logic                en;
  logic                full;
  logic [1:0]          count;
  logic                push;
  logic                pop;
  res_t                buf0;
  res_t                buf1;
  res_t                res;

  logic                v0, v1, v2;
  side_t               s0_side, s1_side, s2_side;
  logic [2*COMP_W-1:0] sqx, sqy, sqz;
  logic [2*COMP_W-1:0] sxy, sz2;

  logic                sq_vld [SQRT_STEPS+1];
  sqrt_t               sq_d   [SQRT_STEPS+1];
  logic                dv_vld [DIV_STEPS+1];
  div_t                dv_d   [DIV_STEPS+1];

  side_t               in_side;
  div_t                prep;
  logic [COMP_W-1:0]   len;
  logic [2*COMP_W-3:0] num [LANES];
  logic [COMP_W-1:0]   mag [LANES];
  logic [COMP_W-1:0]   sat [LANES];
  logic                neg [LANES];
  logic [COMP_W-1:0]   uval [LANES];

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // whole chain moves unless the buffer is full and the tail holds a word
  assign full     = (count == 2'd2);
  assign en       = !(full && dv_vld[DIV_STEPS]);
  assign in_stall = !en;

  // magnitudes and signs
  always_comb begin
    in_side.nx   = in_x[COMP_W-1];
    in_side.ny   = in_y[COMP_W-1];
    in_side.nz   = in_z[COMP_W-1] && !two_dims;
    in_side.mx   = in_x[COMP_W-1] ? (~in_x + 1'b1) : in_x;
    in_side.my   = in_y[COMP_W-1] ? (~in_y + 1'b1) : in_y;
    in_side.mz   = two_dims ? '0 : (in_z[COMP_W-1] ? (~in_z + 1'b1) : in_z);
    in_side.flat = two_dims;
  end

  // front stages: capture, square, partial sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= in_side;
      sqx     <= s0_side.mx * s0_side.mx;
      sqy     <= s0_side.my * s0_side.my;
      sqz     <= s0_side.mz * s0_side.mz;
      s1_side <= s0_side;
      sxy     <= sqx + sqy;
      sz2     <= sqz;
      s2_side <= s1_side;
    end
  end

  // full sum of squares feeds the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[0].rem  <= '0;
      sq_d[0].root <= '0;
      sq_d[0].rad  <= sxy + sz2;
      sq_d[0].side <= s2_side;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    vnorm_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_i (sq_vld[g]),
      .d_i   (sq_d[g]),
      .vld_o (sq_vld[g+1]),
      .d_o   (sq_d[g+1])
    );
  end

  // limit test and rounded numerators
  always_comb begin
    len    = sq_d[SQRT_STEPS].root;
    mag[0] = sq_d[SQRT_STEPS].side.mx;
    mag[1] = sq_d[SQRT_STEPS].side.my;
    mag[2] = sq_d[SQRT_STEPS].side.mz;
    prep   = '0;
    for (int i = 0; i < LANES; i++) begin
      num[i] = {mag[i], 30'b0} + {31'b0, len[COMP_W-1:1]};
      prep.rem[i] = {2'b00, num[i][2*COMP_W-3:COMP_W]};
      prep.low[i] = num[i][COMP_W-1:0];
    end
    prep.len     = len;
    prep.fl.zero = (len <= {{(COMP_W-LIMIT_W){1'b0}}, limit});
    prep.fl.flat = sq_d[SQRT_STEPS].side.flat;
    prep.fl.nx   = sq_d[SQRT_STEPS].side.nx;
    prep.fl.ny   = sq_d[SQRT_STEPS].side.ny;
    prep.fl.nz   = sq_d[SQRT_STEPS].side.nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0] <= prep;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    vnorm_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_i (dv_vld[g]),
      .d_i   (dv_d[g]),
      .vld_o (dv_vld[g+1]),
      .d_o   (dv_d[g+1])
    );
  end

  // saturate, apply sign, zero-length and 2D overrides
  always_comb begin
    neg[0] = dv_d[DIV_STEPS].fl.nx;
    neg[1] = dv_d[DIV_STEPS].fl.ny;
    neg[2] = dv_d[DIV_STEPS].fl.nz;
    for (int i = 0; i < LANES; i++) begin
      sat[i]  = (dv_d[DIV_STEPS].quo[i] > UNIT_ONE) ? UNIT_ONE : dv_d[DIV_STEPS].quo[i];
      uval[i] = neg[i] ? (~sat[i] + 1'b1) : sat[i];
    end
    res.zero = dv_d[DIV_STEPS].fl.zero;
    res.ux   = res.zero ? '0 : uval[0];
    res.uy   = res.zero ? '0 : uval[1];
    res.uz   = (res.zero || dv_d[DIV_STEPS].fl.flat) ? '0 : uval[2];
  end

  // two-entry output buffer, head drives the ports
  assign push = en && dv_vld[DIV_STEPS];
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        buf0 <= res;
      end else begin
        buf1 <= res;
      end
    end else if (pop && !push) begin
      buf0 <= buf1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        buf0 <= res;
      end else begin
        buf0 <= buf1;
        buf1 <= res;
      end
    end
  end

  assign out_valid       = (count != 2'd0);
  assign unit_x          = buf0.ux;
  assign unit_y          = buf0.uy;
  assign unit_z          = buf0.uz;
  assign length_was_zero = buf0.zero;

`include "vector_normalize_macros.svh"

  `VN_ASSERT_NEVER(a_count_range, count == 2'd3, "output buffer count out of range")
  `VN_ASSERT_IMPL(a_zero_clears, out_valid && length_was_zero, unit_x == 0 && unit_y == 0 && unit_z == 0, "zero length word with nonzero components")
  `VN_ASSERT_IMPL(a_unit_bound, out_valid, unit_x <= $signed(UNIT_ONE) && unit_x >= -$signed(UNIT_ONE), "unit_x beyond one")
  `VN_ASSERT_IMPL(a_no_stall_free, !full, !in_stall, "input stalled while output buffer has room")
  `VN_ASSERT_IMPL(a_no_push_full, full && !pop, !push || !en, "push into full output buffer")

endmodule

// ===== tb/tb_vector_normalize.sv =====
// Self-checking testbench for vector_normalize: directed table plus random vectors.
// Depends on vnorm_pkg and the vector_normalize RTL; predicts unit vectors in-line.
module tb_vector_normalize;
  import vnorm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COMP_W-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic two_dims = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COMP_W-1:0] unit_x, unit_y, unit_z;
  logic length_was_zero;

  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [COMP_W-1:0] ux;
    logic [COMP_W-1:0] uy;
    logic [COMP_W-1:0] uz;
    logic              zero;
  } unit_vec_t;

  // directed row: vector, mode, and an optional typed-in answer
  typedef struct {
    logic [COMP_W-1:0] x, y, z;
    logic              flat;
    bit                fixed;
    unit_vec_t         want;
  } vec_row_t;

  unit_vec_t pending_units[$];
  logic [LIMIT_W-1:0] limit_shadow = '0;
  int  fail_count = 0;
  bit  hold_long = 1'b0;
  bit  stim_done = 1'b0;

  vector_normalize dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // truncated integer square root of a 64-bit sum
  function automatic logic [63:0] root_floor(input logic [65:0] n);
    logic [65:0] r, b;
    r = 0;
    b = 66'd1 << 64;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [31:0] scaled_comp(input logic [31:0] m, input bit neg,
                                              input logic [63:0] len);
    logic [95:0] q;
    q = ({64'd0, m} << 30) + {32'd0, len >> 1};
    q = q / {32'd0, len};
    if (q > 96'h4000_0000) q = 96'h4000_0000;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic unit_vec_t predict_unit(input logic [31:0] x, y, z, input logic flat);
    logic [31:0] mx, my, mz;
    bit nx, ny, nz;
    logic [65:0] sum;
    logic [63:0] len;
    unit_vec_t r;
    nx = x[31]; ny = y[31]; nz = z[31] && !flat;
    mx = nx ? -x : x;
    my = ny ? -y : y;
    mz = flat ? 32'd0 : (nz ? -z : z);
    sum = 66'(mx) * 66'(mx) + 66'(my) * 66'(my) + 66'(mz) * 66'(mz);
    len = root_floor(sum);
    r = '0;
    if (len <= 64'(limit_shadow)) begin
      r.zero = 1'b1;
    end else begin
      r.ux = scaled_comp(mx, nx, len);
      r.uy = scaled_comp(my, ny, len);
      r.uz = flat ? 32'd0 : scaled_comp(mz, nz, len);
    end
    return r;
  endfunction

  // valid drops only when a gap follows, so back-to-back words keep it high
  task automatic send_word(input logic [31:0] x, y, z, input logic flat, input bit fixed,
                           input unit_vec_t want, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z; two_dims <= flat;
    pending_units.push_back(fixed ? want : predict_unit(x, y, z, flat));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_shadow = v;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 255) - 128;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom_range(0, 1 << 17) - (1 << 16);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    unit_vec_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_units.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        w = pending_units.pop_front();
        if (unit_x !== w.ux) begin
          $error("unit_x exp %h got %h", w.ux, unit_x); fail_count++;
        end
        if (unit_y !== w.uy) begin
          $error("unit_y exp %h got %h", w.uy, unit_y); fail_count++;
        end
        if (unit_z !== w.uz) begin
          $error("unit_z exp %h got %h", w.uz, unit_z); fail_count++;
        end
        if (length_was_zero !== w.zero) begin
          $error("length_was_zero exp %b got %b", w.zero, length_was_zero); fail_count++;
        end
      end
    end
  end

  // receiver: random stalls per word, or one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall) && !hold_long);
    end
  end

  initial begin
    vec_row_t dir[$];
    vec_row_t row;
    unit_vec_t zv, one;
    logic [LIMIT_W-1:0] lims[5];
    zv = '0; zv.zero = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector, axis units, extremes, 2D mode, fractions
    dir.push_back('{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, zv});
    dir.push_back('{32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, zv});
    one = '0; one.ux = 32'h4000_0000;
    dir.push_back('{32'h0001_0000, 32'd0, 32'd0, 1'b0, 1'b1, one});
    one = '0; one.uy = 32'hC000_0000;
    dir.push_back('{32'd0, 32'hFFFF_0000, 32'd0, 1'b0, 1'b1, one});
    one = '0; one.uz = 32'h4000_0000;
    dir.push_back('{32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, one});
    one = '0; one.ux = 32'hC000_0000;
    dir.push_back('{32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b1, one});
    dir.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, zv});
    dir.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, zv});
    dir.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b0, zv});
    dir.push_back('{32'd1, 32'd1, 32'd1, 1'b0, 1'b0, zv});
    dir.push_back('{32'd3, 32'd4, 32'd0, 1'b1, 1'b0, zv});
    dir.push_back('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, zv});
    dir.push_back('{32'h0003_0000, 32'hFFFC_0000, 32'h0005_0000, 1'b0, 1'b0, zv});
    dir.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, 1'b0, zv});
    foreach (dir[i]) begin
      row = dir[i];
      send_word(row.x, row.y, row.z, row.flat, row.fixed, row.want, 1'b0);
    end

    // threshold settings, extremes included
    lims = '{16'hFFFF, 16'd1, 16'd300, 16'h8000, 16'd0};
    foreach (lims[k]) begin
      set_limit(lims[k]);
      if (k == 1) begin
        // long receiver hold-off while back-to-back words fill the pipeline
        hold_long = 1'b1;
        repeat (100)
          send_word(rand_comp(), rand_comp(), rand_comp(), 1'($urandom_range(0, 1)), 1'b0,
                    zv, 1'b1);
        wait_drain();
      end
      // length right around the threshold
      send_word({16'd0, lims[k]}, 32'd0, 32'd0, 1'b0, 1'b0, zv, 1'b0);
      send_word({16'd0, lims[k]} + 1, 32'd0, 32'd0, 1'b1, 1'b0, zv, 1'b0);
      repeat (70)
        send_word(rand_comp(), rand_comp(), rand_comp(), 1'($urandom_range(0, 1)), 1'b0,
                  zv, $urandom_range(0, 4) == 0);
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
